[src/lipv_pkg.sv]
// Shared types and constants of the recency replacement unit.
package lipv_pkg;

    localparam int POS_W      = 5;
    localparam int REQ_W      = 2;
    localparam int SET_W      = 6;
    localparam int WAY_W      = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;
    localparam int PROMO_W    = 16;
    localparam int INS_W      = 4;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;
    localparam int SET_CMP_W  = 13;

    localparam logic [APB_AW-1:0] ADDR_PROMO0 = 5'h00;
    localparam logic [APB_AW-1:0] ADDR_PROMO1 = 5'h04;
    localparam logic [APB_AW-1:0] ADDR_PROMO2 = 5'h08;
    localparam logic [APB_AW-1:0] ADDR_PROMO3 = 5'h0c;
    localparam logic [APB_AW-1:0] ADDR_INS    = 5'h10;

    localparam logic [PROMO_W-1:0] RST_PROMO0 = 16'd256;
    localparam logic [PROMO_W-1:0] RST_PROMO1 = 16'd8451;
    localparam logic [PROMO_W-1:0] RST_PROMO2 = 16'd5377;
    localparam logic [PROMO_W-1:0] RST_PROMO3 = 16'd45312;
    localparam logic [INS_W-1:0]   RST_INS    = 4'd13;

    typedef enum logic [REQ_W-1:0] {
        REQ_HIT   = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_INV   = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic clr_we;
        logic accept;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
        logic exec_query;
        logic out_blocked;
    } t_dp_status;

endpackage

[src/lru_ipv_replacement_unit.sv]
// Top level of the insertion/promotion-vector recency replacement unit.
// For each item, the accept edge starts the read of the set's row from the row RAM, and the
// execute state then writes the updated row back or loads a query result into the output
// register; a new item is accepted only after the last one is through the single RAM port pair.
// A query whose result would land on a result still untaken waits in the execute state.
// After reset a clearing pass writes the initial positions into every row, during which no
// item is accepted; configuration writes are taken throughout.
module lru_ipv_replacement_unit #(
    parameter int NUM_WAYS = 16,
    parameter int NUM_SETS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [1:0] req_type, [7:2] set_index, [11:8] way_index, [15:12] zero
    input  logic [lipv_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [3:0] victim_way, [4] victim_at_tail, [7:5] zero
    output logic [lipv_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lipv_pkg::APB_AW-1:0]      paddr,
    input  logic [lipv_pkg::APB_DW-1:0]      pwdata,
    output logic [lipv_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import lipv_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    assign pready = 1'b1;

    lipv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_tready)
    );

    lipv_dp #(
        .NUM_WAYS (NUM_WAYS),
        .NUM_SETS (NUM_SETS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata)
    );

endmodule

[src/lipv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lipv_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/lipv_ctrl.sv]
// Controller state machine: clearing pass, accept, read-modify-write or query of one set.
module lipv_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  lipv_pkg::t_dp_status  i_status,
    output lipv_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_s_tready
);
    import lipv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!(i_status.exec_query && i_status.out_blocked)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ST_EXEC: begin
                o_cmd.exec = !(i_status.exec_query && i_status.out_blocked);
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[src/lipv_dp.sv]
// Datapath: config registers, set row storage, row update, victim search, result register.
module lipv_dp #(
    parameter int NUM_WAYS = 16,
    parameter int NUM_SETS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lipv_pkg::t_ctrl_cmd                 i_cmd,
    output lipv_pkg::t_dp_status                o_status,
    input  logic [lipv_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lipv_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lipv_pkg::APB_AW-1:0]         paddr,
    input  logic [lipv_pkg::APB_DW-1:0]         pwdata,
    output logic [lipv_pkg::APB_DW-1:0]         prdata
);
    import lipv_pkg::*;

    localparam int AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW    = $clog2(NUM_WAYS);
    localparam int ROW_W = NUM_WAYS * POS_W;
    localparam logic [POS_W-1:0] PARK = POS_W'(NUM_WAYS);
    localparam logic [POS_W-1:0] TAIL = POS_W'(NUM_WAYS - 1);

    logic [PROMO_W-1:0] r_promo [4];
    logic [INS_W-1:0]   r_ins;
    logic               w_cfg_we;

    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_promo[0] <= RST_PROMO0;
            r_promo[1] <= RST_PROMO1;
            r_promo[2] <= RST_PROMO2;
            r_promo[3] <= RST_PROMO3;
            r_ins      <= RST_INS;
        end else if (w_cfg_we) begin
            case (paddr)
                ADDR_PROMO0: r_promo[0] <= pwdata[PROMO_W-1:0];
                ADDR_PROMO1: r_promo[1] <= pwdata[PROMO_W-1:0];
                ADDR_PROMO2: r_promo[2] <= pwdata[PROMO_W-1:0];
                ADDR_PROMO3: r_promo[3] <= pwdata[PROMO_W-1:0];
                ADDR_INS:    r_ins      <= pwdata[INS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_PROMO0: prdata = APB_DW'(r_promo[0]);
            ADDR_PROMO1: prdata = APB_DW'(r_promo[1]);
            ADDR_PROMO2: prdata = APB_DW'(r_promo[2]);
            ADDR_PROMO3: prdata = APB_DW'(r_promo[3]);
            ADDR_INS:    prdata = APB_DW'(r_ins);
            default:     prdata = '0;
        endcase
    end

    // request capture
    logic [REQ_W-1:0] w_in_req;
    logic [SET_W-1:0] w_in_set;
    logic [WAY_W-1:0] w_in_way;
    logic [AW-1:0]    w_in_addr;

    assign w_in_req  = i_s_tdata[REQ_W-1:0];
    assign w_in_set  = i_s_tdata[REQ_W +: SET_W];
    assign w_in_way  = i_s_tdata[REQ_W+SET_W +: WAY_W];
    assign w_in_addr = AW'(w_in_set);

    t_req             r_req;
    logic [AW-1:0]    r_addr;
    logic [WAY_W-1:0] r_way;
    logic             r_set_ok;
    logic             r_way_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= t_req'(w_in_req);
            r_addr   <= w_in_addr;
            r_way    <= w_in_way;
            r_set_ok <= SET_CMP_W'(w_in_set) < SET_CMP_W'(NUM_SETS);
            r_way_ok <= (POS_W'(w_in_way) < PARK);
        end
    end

    // clearing pass
    logic [AW-1:0] r_clr_addr;
    logic          w_clr_last;

    assign w_clr_last = (r_clr_addr == AW'(NUM_SETS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_we && !w_clr_last) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    logic [ROW_W-1:0] w_reset_row;

    always_comb begin
        for (int k = 0; k < NUM_WAYS; k++) begin
            w_reset_row[k*POS_W +: POS_W] = POS_W'(k);
        end
    end

    // row storage
    logic             w_ram_we;
    logic [AW-1:0]    w_ram_waddr;
    logic [ROW_W-1:0] w_ram_wdata;
    logic [ROW_W-1:0] w_row;
    logic [ROW_W-1:0] w_new_row;
    logic             w_modify;

    assign w_modify    = i_cmd.exec && r_set_ok && r_way_ok && (r_req != REQ_QUERY);
    assign w_ram_we    = i_cmd.clr_we || w_modify;
    assign w_ram_waddr = i_cmd.clr_we ? r_clr_addr : r_addr;
    assign w_ram_wdata = i_cmd.clr_we ? w_reset_row : w_new_row;

    lipv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (w_in_addr),
        .o_rdata (w_row)
    );

    // row update
    logic [POS_W-1:0] w_pos [NUM_WAYS];
    logic [POS_W-1:0] w_clp [NUM_WAYS];
    logic [POS_W-1:0] w_t;
    logic [POS_W-1:0] w_nv;
    logic [PROMO_W-1:0] w_promo_reg;
    logic [INS_W-1:0] w_promo_tgt;

    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            w_pos[i] = w_row[i*POS_W +: POS_W];
            w_clp[i] = (w_pos[i] >= PARK) ? TAIL : w_pos[i];
        end
    end

    assign w_t         = w_clp[r_way[WW-1:0]];
    assign w_promo_reg = r_promo[w_t[3:2]];
    assign w_promo_tgt = w_promo_reg[{w_t[1:0], 2'b00} +: INS_W];
    assign w_nv        = (r_req == REQ_FILL) ? POS_W'(r_ins) : POS_W'(w_promo_tgt);

    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            w_new_row[i*POS_W +: POS_W] = w_pos[i];
            if (r_req == REQ_INV) begin
                if (w_pos[i] == w_t) begin
                    w_new_row[i*POS_W +: POS_W] = PARK;
                end else if (w_pos[i] > w_t && w_pos[i] <= PARK) begin
                    w_new_row[i*POS_W +: POS_W] = w_pos[i] - POS_W'(1);
                end
            end else begin
                if (w_clp[i] == w_t) begin
                    w_new_row[i*POS_W +: POS_W] = w_nv;
                end else if (w_clp[i] >= w_nv && w_clp[i] < w_t) begin
                    w_new_row[i*POS_W +: POS_W] = w_clp[i] + POS_W'(1);
                end
            end
        end
    end

    // victim search
    logic [WAY_W-1:0] w_victim;
    logic             w_tail;

    always_comb begin
        w_victim = '0;
        w_tail   = 1'b0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (w_pos[i] >= TAIL) begin
                w_victim = WAY_W'(i);
                w_tail   = 1'b1;
            end
        end
        if (!r_set_ok) begin
            w_victim = '0;
            w_tail   = 1'b0;
        end
    end

    // result register
    logic             r_out_valid;
    logic [WAY_W-1:0] r_victim;
    logic             r_tail;
    logic             w_load;

    assign w_load = i_cmd.exec && (r_req == REQ_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_victim <= w_victim;
            r_tail   <= w_tail;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_tail, r_victim});

    assign o_status.clr_last    = w_clr_last;
    assign o_status.exec_query  = (r_req == REQ_QUERY);
    assign o_status.out_blocked = r_out_valid && !i_m_tready;

endmodule
